@@ rtl/s3fp_pkg.sv @@
// ----------------------------------------------------------------------------
// s3fp_pkg
// Shared types and constants for the S3-FIFO page replacement unit.
// ----------------------------------------------------------------------------
package s3fp_pkg;

    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int FREQ_W    = 2;

    localparam logic [FREQ_W-1:0] FREQ_MAX = 2'd3;
    localparam logic [FREQ_W-1:0] FREQ_HOT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SMALL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAIN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GHOST = 2'd3;

    localparam logic [CFG_W-1:0] RST_TOTAL = 7'd64;
    localparam logic [CFG_W-1:0] RST_SMALL = 7'd6;
    localparam logic [CFG_W-1:0] RST_MAIN  = 7'd58;
    localparam logic [CFG_W-1:0] RST_GHOST = 7'd6;

    typedef enum logic {
        OP_REF,
        OP_INV
    } t_op;

    typedef enum logic [1:0] {
        Q_SMALL,
        Q_MAIN,
        Q_GHOST
    } t_queue;

    typedef enum logic [1:0] {
        CTX_PROMO,
        CTX_SMALL,
        CTX_LOOP
    } t_ctx;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_INV_S,
        ST_INV_M,
        ST_INV_G,
        ST_RM,
        ST_SH_RD,
        ST_SH_WR,
        ST_PROMO,
        ST_PUSH_PR,
        ST_PUSH_GH,
        ST_PUSH_SM,
        ST_EVM_RD,
        ST_EVM_EX,
        ST_LOOP,
        ST_EVS_RD,
        ST_EVS_EX,
        ST_DONE
    } t_state;

endpackage

@@ rtl/s3fp_ram.sv @@
// ----------------------------------------------------------------------------
// s3fp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module s3fp_ram #(
    parameter int W     = 22,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/s3fp_front.sv @@
// ----------------------------------------------------------------------------
// s3fp_front
// Input side: accept transactions, decode the request and queue commands.
// ----------------------------------------------------------------------------
module s3fp_front #(
    parameter int PAGE_BITS = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_req_type,
    input  logic [PAGE_BITS-1:0] i_page_number,
    output logic                 o_cmd_valid,
    input  logic                 i_cmd_ready,
    output s3fp_pkg::t_op        o_cmd_op,
    output logic [PAGE_BITS-1:0] o_cmd_page
);
    import s3fp_pkg::*;

    t_op                  r_op [2];
    logic [PAGE_BITS-1:0] r_pg [2];
    logic                 r_wp, r_rp;
    logic [1:0]           r_cnt;
    logic                 push, pop;

    assign o_ready     = (r_cnt != 2'd2);
    assign push        = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd_op    = r_op[r_rp];
    assign o_cmd_page  = r_pg[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
        if (push) begin
            r_op[r_wp] <= i_req_type ? OP_INV : OP_REF;
            r_pg[r_wp] <= i_page_number;
        end
    end
endmodule

@@ rtl/s3fp_back.sv @@
// ----------------------------------------------------------------------------
// s3fp_back
// Execution engine: queue search, update, eviction and result register.
// ----------------------------------------------------------------------------
module s3fp_back #(
    parameter int CAPACITY  = 64,
    parameter int PAGE_BITS = 20
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cmd_valid,
    output logic                           o_cmd_ready,
    input  s3fp_pkg::t_op                  i_cmd_op,
    input  logic [PAGE_BITS-1:0]           i_cmd_page,
    input  logic                           i_cfg_we,
    input  logic [s3fp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [s3fp_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_hit,
    output logic                           o_victim_valid,
    output logic [PAGE_BITS-1:0]           o_victim_page,
    output logic                           o_dropped_valid,
    output logic [PAGE_BITS-1:0]           o_dropped_page
);
    import s3fp_pkg::*;

    localparam int AW   = $clog2(CAPACITY + 1);
    localparam int PD   = 1 << AW;
    localparam int CW   = $clog2(CAPACITY + 2);
    localparam int CMPW = ((CW > CFG_W) ? CW : CFG_W) + 1;
    localparam int W    = PAGE_BITS + FREQ_W;

    t_state r_state, n_state, r_ret, n_ret;
    t_op    r_op, n_op;
    t_queue r_rq, n_rq;
    t_ctx   r_ctx, n_ctx;
    logic [PAGE_BITS-1:0] r_page, n_page, r_sp, n_sp, r_vp, n_vp, r_dp, n_dp;
    logic [CW-1:0] r_k, n_k, r_pk, n_pk, r_ri, n_ri;
    logic [CW-1:0] r_si, n_si, r_mi, n_mi, r_gi, n_gi;
    logic [CW-1:0] r_ns, n_ns, r_nm, n_nm, r_ng, n_ng;
    logic [AW-1:0] r_ts, n_ts, r_tm, n_tm, r_tg, n_tg;
    logic r_pv, n_pv, r_fs, n_fs, r_fm, n_fm, r_fg, n_fg, r_vv, n_vv, r_dv, n_dv;
    logic [FREQ_W-1:0] r_sf, n_sf, r_mf, n_mf;
    logic r_ovalid, n_ovalid, r_ohit, n_ohit, r_ovv, n_ovv, r_odv, n_odv;
    logic [PAGE_BITS-1:0] r_ovp, n_ovp, r_odp, n_odp;
    logic [CFG_W-1:0] r_cfg_total, r_cfg_small, r_cfg_main, r_cfg_ghost;

    // RAM ports
    logic          s_we, m_we, g_we;
    logic [AW-1:0] s_wa, m_wa, g_wa, s_ra, m_ra, g_ra;
    logic [W-1:0]  s_wd, m_wd, s_rd, m_rd;
    logic [PAGE_BITS-1:0] g_wd, g_rd;

    // helpers
    logic [CW-1:0]   rd_off, max_n, sel_cnt;
    logic [W-1:0]    sel_rd;
    logic [AW-1:0]   sel_tail;
    logic [CMPW-1:0] tot_cap, gh_cap, sum_n;
    logic            scan_issue, loop_done, loop_small, room_main, out_free;
    logic            s_room, m_room;

    s3fp_ram #(.W(W), .DEPTH(PD)) u_small (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_wa), .i_wdata(s_wd),
        .i_raddr(s_ra), .o_rdata(s_rd));
    s3fp_ram #(.W(W), .DEPTH(PD)) u_main (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_wa), .i_wdata(m_wd),
        .i_raddr(m_ra), .o_rdata(m_rd));
    s3fp_ram #(.W(PAGE_BITS), .DEPTH(PD)) u_ghost (
        .i_clk(i_clk), .i_we(g_we), .i_waddr(g_wa), .i_wdata(g_wd),
        .i_raddr(g_ra), .o_rdata(g_rd));

    always_comb begin
        case (r_state)
            ST_SCAN:  rd_off = r_k;
            ST_SH_RD: rd_off = r_k + 1'b1;
            default:  rd_off = '0;
        endcase
    end

    assign s_ra = r_ts + rd_off[AW-1:0];
    assign m_ra = r_tm + rd_off[AW-1:0];
    assign g_ra = r_tg + rd_off[AW-1:0];

    always_comb begin
        max_n = r_ns;
        if (r_nm > max_n) max_n = r_nm;
        if (r_ng > max_n) max_n = r_ng;
    end
    assign scan_issue = (r_k < max_n);

    always_comb begin
        case (r_rq)
            Q_SMALL: begin sel_cnt = r_ns; sel_tail = r_ts; sel_rd = s_rd; end
            Q_MAIN:  begin sel_cnt = r_nm; sel_tail = r_tm; sel_rd = m_rd; end
            default: begin sel_cnt = r_ng; sel_tail = r_tg; sel_rd = {g_rd, {FREQ_W{1'b0}}}; end
        endcase
    end

    assign tot_cap = (CMPW'(r_cfg_total) > CMPW'(CAPACITY)) ? CMPW'(CAPACITY)
                                                            : CMPW'(r_cfg_total);
    assign gh_cap  = (CMPW'(r_cfg_ghost) > CMPW'(CAPACITY)) ? CMPW'(CAPACITY)
                                                            : CMPW'(r_cfg_ghost);
    assign sum_n      = CMPW'(r_ns) + CMPW'(r_nm);
    assign loop_done  = r_vv || (sum_n <= tot_cap);
    assign loop_small = (r_ns != '0) && (CMPW'(r_ns) >= CMPW'(r_cfg_small));
    assign room_main  = (r_nm != '0) && (CMPW'(r_nm) >= CMPW'(r_cfg_main));
    assign out_free   = !r_ovalid || i_ready;
    // a full queue (capacity plus one slack slot) drops a further push
    assign s_room     = (CMPW'(r_ns) < CMPW'(CAPACITY + 1));
    assign m_room     = (CMPW'(r_nm) < CMPW'(CAPACITY + 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:    if (i_cmd_valid) n_state = ST_SCAN;
            ST_SCAN:    if (!scan_issue && !r_pv) n_state = ST_DECIDE;
            ST_DECIDE: begin
                if (r_op == OP_INV)    n_state = ST_INV_S;
                else if (r_fm)         n_state = ST_DONE;
                else if (r_fs)         n_state = (r_sf == '0) ? ST_RM : ST_DONE;
                else if (r_fg)         n_state = ST_RM;
                else                   n_state = ST_LOOP;
            end
            ST_INV_S:   n_state = r_fs ? ST_RM : ST_INV_M;
            ST_INV_M:   n_state = r_fm ? ST_RM : ST_INV_G;
            ST_INV_G:   n_state = r_fg ? ST_RM : ST_DONE;
            ST_RM: begin
                if (r_ri == '0 || r_ri == sel_cnt - 1'b1) n_state = r_ret;
                else                                       n_state = ST_SH_RD;
            end
            ST_SH_RD:   n_state = ST_SH_WR;
            ST_SH_WR:   n_state = (r_k + 1'b1 == sel_cnt - 1'b1) ? r_ret : ST_SH_RD;
            ST_PROMO:   n_state = room_main ? ST_EVM_RD : ST_PUSH_PR;
            ST_PUSH_PR: n_state = ST_DONE;
            ST_PUSH_GH: n_state = ST_LOOP;
            ST_PUSH_SM: n_state = ST_LOOP;
            ST_EVM_RD:  n_state = ST_EVM_EX;
            ST_EVM_EX: begin
                case (r_ctx)
                    CTX_PROMO: n_state = ST_PUSH_PR;
                    CTX_SMALL: n_state = ST_PUSH_SM;
                    default:   n_state = ST_LOOP;
                endcase
            end
            ST_LOOP: begin
                if (loop_done)        n_state = ST_DONE;
                else if (loop_small)  n_state = ST_EVS_RD;
                else if (r_nm != '0)  n_state = ST_EVM_RD;
                else                  n_state = ST_DONE;
            end
            ST_EVS_RD:  n_state = ST_EVS_EX;
            ST_EVS_EX: begin
                if (s_rd[FREQ_W-1:0] >= FREQ_HOT) n_state = room_main ? ST_EVM_RD : ST_PUSH_SM;
                else                               n_state = ST_LOOP;
            end
            ST_DONE:    if (out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // datapath and RAM controls
    always_comb begin
        n_op = r_op; n_page = r_page; n_sp = r_sp; n_k = r_k; n_pk = r_pk; n_pv = r_pv;
        n_fs = r_fs; n_fm = r_fm; n_fg = r_fg; n_si = r_si; n_mi = r_mi; n_gi = r_gi;
        n_sf = r_sf; n_mf = r_mf; n_ns = r_ns; n_nm = r_nm; n_ng = r_ng;
        n_ts = r_ts; n_tm = r_tm; n_tg = r_tg; n_rq = r_rq; n_ri = r_ri; n_ret = r_ret;
        n_ctx = r_ctx; n_vv = r_vv; n_vp = r_vp; n_dv = r_dv; n_dp = r_dp;
        n_ovalid = r_ovalid && !i_ready;
        n_ohit = r_ohit; n_ovv = r_ovv; n_ovp = r_ovp; n_odv = r_odv; n_odp = r_odp;
        s_we = 1'b0; s_wa = r_ts; s_wd = {r_page, {FREQ_W{1'b0}}};
        m_we = 1'b0; m_wa = r_tm; m_wd = {r_page, {FREQ_W{1'b0}}};
        g_we = 1'b0; g_wa = r_tg; g_wd = r_page;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_op = i_cmd_op; n_page = i_cmd_page;
                    n_k = '0; n_pv = 1'b0;
                    n_fs = 1'b0; n_fm = 1'b0; n_fg = 1'b0;
                    n_vv = 1'b0; n_vp = '0; n_dv = 1'b0; n_dp = '0;
                end
            end
            ST_SCAN: begin
                if (r_pv) begin
                    if (!r_fs && r_pk < r_ns && s_rd[W-1:FREQ_W] == r_page) begin
                        n_fs = 1'b1; n_si = r_pk; n_sf = s_rd[FREQ_W-1:0];
                    end
                    if (!r_fm && r_pk < r_nm && m_rd[W-1:FREQ_W] == r_page) begin
                        n_fm = 1'b1; n_mi = r_pk; n_mf = m_rd[FREQ_W-1:0];
                    end
                    if (!r_fg && r_pk < r_ng && g_rd == r_page) begin
                        n_fg = 1'b1; n_gi = r_pk;
                    end
                end
                n_pv = scan_issue;
                n_pk = r_k;
                if (scan_issue) n_k = r_k + 1'b1;
            end
            ST_DECIDE: begin
                if (r_op == OP_INV) begin
                    n_ret = ST_INV_M;
                end else if (r_fm) begin
                    m_we = 1'b1;
                    m_wa = r_tm + r_mi[AW-1:0];
                    m_wd = {r_page, (r_mf == FREQ_MAX) ? r_mf : r_mf + 1'b1};
                end else if (r_fs) begin
                    if (r_sf == '0) begin
                        n_rq = Q_SMALL; n_ri = r_si; n_ret = ST_PROMO;
                    end else if (r_sf != FREQ_MAX) begin
                        s_we = 1'b1;
                        s_wa = r_ts + r_si[AW-1:0];
                        s_wd = {r_page, r_sf + 1'b1};
                    end
                end else if (r_fg) begin
                    n_rq = Q_GHOST; n_ri = r_gi; n_ret = ST_PUSH_GH;
                end else if (s_room) begin
                    s_we = 1'b1;
                    s_wa = r_ts + r_ns[AW-1:0];
                    n_ns = r_ns + 1'b1;
                end
            end
            ST_INV_S: begin n_rq = Q_SMALL; n_ri = r_si; n_ret = ST_INV_M; end
            ST_INV_M: begin n_rq = Q_MAIN;  n_ri = r_mi; n_ret = ST_INV_G; end
            ST_INV_G: begin n_rq = Q_GHOST; n_ri = r_gi; n_ret = ST_DONE;  end
            ST_RM: begin
                if (r_ri == '0) begin
                    // tail removal: advance the tail pointer
                    case (r_rq)
                        Q_SMALL: begin n_ts = r_ts + 1'b1; n_ns = r_ns - 1'b1; end
                        Q_MAIN:  begin n_tm = r_tm + 1'b1; n_nm = r_nm - 1'b1; end
                        default: begin n_tg = r_tg + 1'b1; n_ng = r_ng - 1'b1; end
                    endcase
                end else if (r_ri == sel_cnt - 1'b1) begin
                    case (r_rq)
                        Q_SMALL: n_ns = r_ns - 1'b1;
                        Q_MAIN:  n_nm = r_nm - 1'b1;
                        default: n_ng = r_ng - 1'b1;
                    endcase
                end else begin
                    n_k = r_ri;
                end
            end
            ST_SH_WR: begin
                // close the gap one slot per pass
                case (r_rq)
                    Q_SMALL: begin s_we = 1'b1; s_wa = sel_tail + r_k[AW-1:0]; s_wd = sel_rd; end
                    Q_MAIN:  begin m_we = 1'b1; m_wa = sel_tail + r_k[AW-1:0]; m_wd = sel_rd; end
                    default: begin
                        g_we = 1'b1; g_wa = sel_tail + r_k[AW-1:0];
                        g_wd = sel_rd[W-1:FREQ_W];
                    end
                endcase
                n_k = r_k + 1'b1;
                if (r_k + 1'b1 == sel_cnt - 1'b1) begin
                    case (r_rq)
                        Q_SMALL: n_ns = r_ns - 1'b1;
                        Q_MAIN:  n_nm = r_nm - 1'b1;
                        default: n_ng = r_ng - 1'b1;
                    endcase
                end
            end
            ST_PROMO: n_ctx = CTX_PROMO;
            ST_PUSH_PR, ST_PUSH_GH: begin
                if (m_room) begin
                    m_we = 1'b1; m_wa = r_tm + r_nm[AW-1:0]; n_nm = r_nm + 1'b1;
                end
            end
            ST_PUSH_SM: begin
                if (m_room) begin
                    m_we = 1'b1; m_wa = r_tm + r_nm[AW-1:0];
                    m_wd = {r_sp, {FREQ_W{1'b0}}};
                    n_nm = r_nm + 1'b1;
                end
            end
            ST_EVM_EX: begin
                n_tm = r_tm + 1'b1;
                if (m_rd[FREQ_W-1:0] != '0) begin
                    // second chance: back to the head with one less
                    m_we = 1'b1;
                    m_wa = r_tm + r_nm[AW-1:0];
                    m_wd = {m_rd[W-1:FREQ_W], m_rd[FREQ_W-1:0] - 1'b1};
                end else begin
                    n_nm = r_nm - 1'b1;
                    if (r_ctx == CTX_PROMO) begin
                        n_dv = 1'b1; n_dp = m_rd[W-1:FREQ_W];
                    end else begin
                        n_vv = 1'b1; n_vp = m_rd[W-1:FREQ_W];
                    end
                end
            end
            ST_LOOP: n_ctx = CTX_LOOP;
            ST_EVS_EX: begin
                n_ts = r_ts + 1'b1;
                n_ns = r_ns - 1'b1;
                n_ctx = CTX_SMALL;
                if (s_rd[FREQ_W-1:0] >= FREQ_HOT) begin
                    n_sp = s_rd[W-1:FREQ_W];
                end else begin
                    g_we = 1'b1;
                    g_wa = r_tg + r_ng[AW-1:0];
                    g_wd = s_rd[W-1:FREQ_W];
                    if (CMPW'(r_ng) + 1'b1 > gh_cap) n_tg = r_tg + 1'b1;
                    else                             n_ng = r_ng + 1'b1;
                    n_vv = 1'b1;
                    n_vp = s_rd[W-1:FREQ_W];
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ohit = r_fs || r_fm;
                    n_ovv = r_vv; n_ovp = r_vp;
                    n_odv = r_dv; n_odp = r_dp;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ns <= '0; r_nm <= '0; r_ng <= '0;
            r_ts <= '0; r_tm <= '0; r_tg <= '0;
            r_pv <= 1'b0;
            r_ovalid <= 1'b0;
            r_cfg_total <= RST_TOTAL;
            r_cfg_small <= RST_SMALL;
            r_cfg_main  <= RST_MAIN;
            r_cfg_ghost <= RST_GHOST;
        end else begin
            r_state  <= n_state;
            r_ns <= n_ns; r_nm <= n_nm; r_ng <= n_ng;
            r_ts <= n_ts; r_tm <= n_tm; r_tg <= n_tg;
            r_pv <= n_pv;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TOTAL: r_cfg_total <= i_cfg_data;
                    REG_SMALL: r_cfg_small <= i_cfg_data;
                    REG_MAIN:  r_cfg_main  <= i_cfg_data;
                    REG_GHOST: r_cfg_ghost <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_op <= n_op; r_page <= n_page; r_sp <= n_sp; r_k <= n_k; r_pk <= n_pk;
        r_fs <= n_fs; r_fm <= n_fm; r_fg <= n_fg; r_si <= n_si; r_mi <= n_mi; r_gi <= n_gi;
        r_sf <= n_sf; r_mf <= n_mf; r_rq <= n_rq; r_ri <= n_ri; r_ret <= n_ret;
        r_ctx <= n_ctx; r_vv <= n_vv; r_vp <= n_vp; r_dv <= n_dv; r_dp <= n_dp;
        r_ohit <= n_ohit; r_ovv <= n_ovv; r_ovp <= n_ovp; r_odv <= n_odv; r_odp <= n_odp;
    end

    assign o_cmd_ready     = (r_state == ST_IDLE);
    assign o_valid         = r_ovalid;
    assign o_hit           = r_ohit;
    assign o_victim_valid  = r_ovv;
    assign o_victim_page   = r_ovp;
    assign o_dropped_valid = r_odv;
    assign o_dropped_page  = r_odp;

    ap_sum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (CMPW'(r_ns) + CMPW'(r_nm) <= CMPW'(CAPACITY + 1)))
        else $error("small plus main beyond capacity");
    ap_ghost_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (CMPW'(r_ng) <= CMPW'(CAPACITY)))
        else $error("ghost queue beyond capacity");
    ap_victim_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !(r_ovv && r_odv))
        else $error("victim and drop in one transaction");
endmodule

@@ rtl/s3fifo_page_replacement_unit.sv @@
// ----------------------------------------------------------------------------
// s3fifo_page_replacement_unit
// S3-FIFO page replacement policy with small, main and ghost queues.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (i_valid/o_ready) carries one transaction per page
//   reference (i_req_type 0) or invalidation (i_req_type 1). Result channel
//   (o_valid/i_ready) returns exactly one transaction per request: hit flag,
//   evicted victim and page dropped by a promotion, in request order.
//   Configuration is a plain write port (i_cfg_we/i_cfg_idx/i_cfg_data); the
//   user must use it only while the unit is idle; the block does not enforce it.
// Operation:
//   One request is worked on at a time. Each request first scans the queues,
//   one slot per cycle over the longest queue, then decides. Removal from the
//   middle of a queue shifts later slots down one by one, each read and then
//   written back; a tail removal only advances the tail pointer. A miss may
//   retry main eviction several times, each attempt reading the tail slot first.
// Reset: all queues empty, capacities 64/6/58/6. Queue RAMs need no clearing.
// Stall: a two-entry command queue keeps accepting while the engine works,
//   until full; the result register holds until taken, and the engine waits on it.
// ----------------------------------------------------------------------------
module s3fifo_page_replacement_unit #(
    parameter int CAPACITY  = 64,
    parameter int PAGE_BITS = 20
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_req_type,
    input  logic [PAGE_BITS-1:0]           i_page_number,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_hit,
    output logic                           o_victim_valid,
    output logic [PAGE_BITS-1:0]           o_victim_page,
    output logic                           o_dropped_valid,
    output logic [PAGE_BITS-1:0]           o_dropped_page,
    input  logic                           i_cfg_we,
    input  logic [s3fp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [s3fp_pkg::CFG_W-1:0]     i_cfg_data
);
    import s3fp_pkg::*;

    // command hand-off between the front and the engine
    logic                 cmd_valid, cmd_ready;
    t_op                  cmd_op;
    logic [PAGE_BITS-1:0] cmd_page;

    // front: accept and decode, buffer up to two commands
    s3fp_front #(.PAGE_BITS(PAGE_BITS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_page_number (i_page_number),
        .o_cmd_valid   (cmd_valid),
        .i_cmd_ready   (cmd_ready),
        .o_cmd_op      (cmd_op),
        .o_cmd_page    (cmd_page)
    );

    // engine: search, update and evict, then hold the result
    s3fp_back #(.CAPACITY(CAPACITY), .PAGE_BITS(PAGE_BITS)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (cmd_valid),
        .o_cmd_ready     (cmd_ready),
        .i_cmd_op        (cmd_op),
        .i_cmd_page      (cmd_page),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_hit           (o_hit),
        .o_victim_valid  (o_victim_valid),
        .o_victim_page   (o_victim_page),
        .o_dropped_valid (o_dropped_valid),
        .o_dropped_page  (o_dropped_page)
    );
endmodule

@@ tb/s3fifo_page_replacement_unit_tb.sv @@
// ----------------------------------------------------------------------------
// s3fifo_page_replacement_unit_tb
// Self-checking bench: references and invalidations are sent over the request
// channel, a behavioural S3-FIFO predictor computes the result of each one,
// and every returned transaction is compared field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module s3fifo_page_replacement_unit_tb;
    import s3fp_pkg::*;

    localparam int CAP     = 64;
    localparam int PB      = 20;
    localparam int LIMIT   = 20000000;
    localparam int N_RAND  = 1950;

    typedef struct packed {
        t_op           op;
        logic [PB-1:0] page;
    } t_req;

    typedef struct packed {
        logic          hit;
        logic          vv;
        logic [PB-1:0] vp;
        logic          dv;
        logic [PB-1:0] dp;
    } t_res;

    typedef struct {
        logic [PB-1:0] page;
        logic [1:0]    freq;
    } t_slot;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic                 i_req_type;
    logic [PB-1:0]        i_page_number;
    logic                 o_valid;
    logic                 i_ready;
    logic                 o_hit;
    logic                 o_victim_valid;
    logic [PB-1:0]        o_victim_page;
    logic                 o_dropped_valid;
    logic [PB-1:0]        o_dropped_page;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    s3fifo_page_replacement_unit #(.CAPACITY(CAP), .PAGE_BITS(PB)) DUT (.*);

    // Predictor state: queues held oldest first, as in the block.
    t_slot       small_q[$];
    t_slot       main_q[$];
    logic [PB-1:0] ghost_q[$];
    int unsigned cap_total, cap_small, cap_main, cap_ghost;

    t_req  pending_reqs[$];
    t_res  expected_res[$];
    int    n_errors;
    int    n_results;
    int    n_hits, n_victims, n_drops;
    longint cycle;
    bit    calm;        // no idling in the closing part of the run

    task automatic report(input string what, input logic [PB-1:0] got, input logic [PB-1:0] want);
        $display("mismatch at cycle %0d, result %0d: %s got %h want %h",
                 cycle, n_results, what, got, want);
        n_errors++;
    endtask

    function automatic t_slot fresh_slot(input logic [PB-1:0] page);
        t_slot s;
        s.page = page;
        s.freq = 2'd0;
        return s;
    endfunction

    // Small and main each hold their capacity plus one slack slot; a further push is dropped.
    function automatic void main_append(input t_slot s);
        if (main_q.size() < CAP + 1) main_q.insert(main_q.size(), s);
    endfunction

    // One main eviction attempt; returns 1 when the tail leaves the cache.
    function automatic bit main_evict(output logic [PB-1:0] vic);
        t_slot s;
        vic = '0;
        if (main_q.size() == 0) return 0;
        s = main_q[0];
        main_q.delete(0);
        if (s.freq > 0) begin
            s.freq--;
            main_q.insert(main_q.size(), s);
            return 0;
        end
        vic = s.page;
        return 1;
    endfunction

    function automatic bit main_make_room(output logic [PB-1:0] vic);
        vic = '0;
        if (main_q.size() >= cap_main) return main_evict(vic);
        return 0;
    endfunction

    function automatic bit small_evict(output logic [PB-1:0] vic);
        t_slot s;
        bit    got;
        int    gcap;
        vic = '0;
        if (small_q.size() == 0) return 0;
        s = small_q[0];
        small_q.delete(0);
        if (s.freq >= FREQ_HOT) begin
            got = main_make_room(vic);
            main_append(fresh_slot(s.page));
            return got;
        end
        gcap = (cap_ghost > CAP) ? CAP : cap_ghost;
        ghost_q.insert(ghost_q.size(), s.page);
        if (ghost_q.size() > gcap) ghost_q.delete(0);
        vic = s.page;
        return 1;
    endfunction

    // Work out the result of one request and advance the predicted state.
    function automatic t_res page_outcome(input t_req r);
        t_res  o;
        int    si, mi, gi, cap;
        logic [PB-1:0] vic;
        o = '0;
        si = -1; mi = -1; gi = -1;
        foreach (small_q[k]) if (si < 0 && small_q[k].page == r.page) si = k;
        foreach (main_q[k])  if (mi < 0 && main_q[k].page == r.page) mi = k;
        foreach (ghost_q[k]) if (gi < 0 && ghost_q[k] == r.page) gi = k;
        o.hit = (si >= 0) || (mi >= 0);
        if (r.op == OP_INV) begin
            if (si >= 0) small_q.delete(si);
            if (mi >= 0) main_q.delete(mi);
            if (gi >= 0) ghost_q.delete(gi);
        end else if (mi >= 0) begin
            if (main_q[mi].freq < FREQ_MAX) main_q[mi].freq++;
        end else if (si >= 0) begin
            if (small_q[si].freq == 0) begin
                small_q.delete(si);
                o.dv = main_make_room(vic);
                if (o.dv) o.dp = vic;
                main_append(fresh_slot(r.page));
            end else if (small_q[si].freq < FREQ_MAX) begin
                small_q[si].freq++;
            end
        end else begin
            cap = (cap_total > CAP) ? CAP : cap_total;
            if (gi >= 0) begin
                ghost_q.delete(gi);
                main_append(fresh_slot(r.page));
            end else if (small_q.size() < CAP + 1) begin
                small_q.insert(small_q.size(), fresh_slot(r.page));
            end
            while (!o.vv && small_q.size() + main_q.size() > cap) begin
                if (small_q.size() != 0 && small_q.size() >= cap_small)
                    o.vv = small_evict(vic);
                else if (main_q.size() != 0)
                    o.vv = main_evict(vic);
                else
                    break;
            end
            if (o.vv) o.vp = vic;
        end
        return o;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Driver: hold each transaction until accepted, with random gap bursts.
    // The head of the pending queue is the transaction on the wires.
    int gap_left;
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            gap_left <= 0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) pending_reqs.delete(0);
            if (gap_left > 0) begin
                i_valid  <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                i_valid  <= 1'b0;
                gap_left <= $urandom_range(0, 2);
            end else if (pending_reqs.size() > 0) begin
                i_valid       <= 1'b1;
                i_req_type    <= pending_reqs[0].op;
                i_page_number <= pending_reqs[0].page;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Predict at acceptance so the order matches the block's.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready)
            expected_res.insert(expected_res.size(),
                                page_outcome('{t_op'(i_req_type), i_page_number}));
    end

    // Monitor: random stall bursts on the result side, compare every result.
    int stall_left;
    always @(posedge i_clk) begin
        t_res w;
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_res.size() == 0) begin
                    report("unexpected result", '0, '0);
                end else begin
                    w = expected_res[0];
                    expected_res.delete(0);
                    if (o_hit !== w.hit) report("hit", o_hit, w.hit);
                    if (o_victim_valid !== w.vv) report("victim_valid", o_victim_valid, w.vv);
                    if (o_victim_page !== w.vp) report("victim_page", o_victim_page, w.vp);
                    if (o_dropped_valid !== w.dv) report("dropped_valid", o_dropped_valid, w.dv);
                    if (o_dropped_page !== w.dp) report("dropped_page", o_dropped_page, w.dp);
                    n_hits    <= n_hits + w.hit;
                    n_victims <= n_victims + w.vv;
                    n_drops   <= n_drops + w.dv;
                end
                n_results <= n_results + 1;
            end
            if (stall_left > 0) begin
                i_ready    <= 1'b0;
                stall_left <= stall_left - 1;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                i_ready    <= 1'b0;
                stall_left <= $urandom_range(0, 2);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Timeout guard.
    always @(posedge i_clk) begin
        if (cycle > LIMIT) begin
            $display("timeout after %0d cycles", cycle);
            $display("s3fifo_page_replacement_unit_tb: errors");
            $finish;
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_TOTAL: cap_total = val;
            REG_SMALL: cap_small = val;
            REG_MAIN:  cap_main  = val;
            default:   cap_ghost = val;
        endcase
    endtask

    task automatic queue_req(input t_op op, input logic [PB-1:0] page);
        t_req r;
        r.op = op;
        r.page = page;
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    // Wait for the block to drain, then a margin for any trailing work.
    task automatic drain();
        while (pending_reqs.size() != 0 || i_valid || expected_res.size() != 0)
            @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    // Mostly reuse a small working set so hits, promotions and ghosts occur.
    function automatic t_req pick_req(input int span);
        t_req r;
        r.op = ($urandom_range(0, 15) == 0) ? OP_INV : OP_REF;
        if ($urandom_range(0, 19) == 0) r.page = PB'($urandom);
        else r.page = PB'(20'h5A000 + $urandom_range(0, span));
        return r;
    endfunction

    task automatic run_phase(input int n, input int span);
        repeat (n) pending_reqs.insert(pending_reqs.size(), pick_req(span));
        drain();
    endtask

    int unsigned cfg_sets[6][4] = '{
        '{64, 6, 58, 6}, '{1, 1, 1, 1}, '{4, 2, 2, 3},
        '{127, 127, 127, 127}, '{0, 0, 0, 0}, '{12, 3, 9, 64}
    };

    initial begin
        i_rst_n = 1'b0; i_valid = 1'b0; i_ready = 1'b0;
        i_req_type = 1'b0; i_page_number = '0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        cycle = 0; n_errors = 0; n_results = 0; calm = 0;
        n_hits = 0; n_victims = 0; n_drops = 0;
        cap_total = RST_TOTAL; cap_small = RST_SMALL;
        cap_main = RST_MAIN; cap_ghost = RST_GHOST;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: page extremes, hit, promotion, invalidate, ghost return.
        queue_req(OP_REF, 20'h00000);
        queue_req(OP_REF, 20'hFFFFF);
        queue_req(OP_REF, 20'h00000);
        queue_req(OP_REF, 20'hFFFFF);
        queue_req(OP_REF, 20'hFFFFF);
        queue_req(OP_INV, 20'hFFFFF);
        queue_req(OP_INV, 20'h12345);
        queue_req(OP_REF, 20'hAAAAA);
        queue_req(OP_REF, 20'h55555);
        drain();
        cfg_write(REG_TOTAL, 2); cfg_write(REG_SMALL, 1);
        cfg_write(REG_MAIN, 1);  cfg_write(REG_GHOST, 2);
        for (int k = 0; k < 8; k++) queue_req(OP_REF, PB'(20'h00100 + k % 4));
        queue_req(OP_INV, 20'h00100);
        drain();

        // Random phases over several settings, extremes included.
        foreach (cfg_sets[s]) begin
            cfg_write(REG_TOTAL, cfg_sets[s][0]); cfg_write(REG_SMALL, cfg_sets[s][1]);
            cfg_write(REG_MAIN, cfg_sets[s][2]);  cfg_write(REG_GHOST, cfg_sets[s][3]);
            if (s == 5) calm = 1;
            run_phase(N_RAND / 6, (s == 3) ? 90 : 24);
        end

        $display("%0d results checked: %0d hits, %0d victims, %0d promotion drops,",
                 n_results, n_hits, n_victims, n_drops);
        $display("over six capacity settings including the zero and saturated extremes");
        if (n_errors == 0) begin
            $display("s3fifo_page_replacement_unit_tb: clean");
        end else begin
            $display("s3fifo_page_replacement_unit_tb: errors");
        end
        $finish;
    end

endmodule
